@@ src/sscc_pkg.sv @@
// Shared types and constants for the size class slot cache.
package sscc_pkg;

  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = 16;
  localparam int LEN_BITS         = 16;
  localparam int LOW_MARK_BITS    = 5;
  localparam int STATUS_BITS      = 3;
  localparam int CLASS_FIELD_BITS = 3;
  localparam int CFG_CLASS_REGS   = 6;
  localparam int RELEASE_BUDGET   = 16;
  localparam int BUDGET_BITS      = 5;

  // register indexes beyond the class sizes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_LEN = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_MARK    = 3'd7;

  localparam logic [LEN_BITS-1:0]      CLASS_SIZE_BASE   = 16'd64;
  localparam logic [LEN_BITS-1:0]      DEFAULT_LEN_RESET = 16'd2048;
  localparam logic [LOW_MARK_BITS-1:0] LOW_MARK_RESET    = 5'd16;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_GRANTED  = 3'd0,
    ST_NO_FIT   = 3'd1,
    ST_NEW_PAGE = 3'd2,
    ST_CACHED   = 3'd3,
    ST_RELEASE  = 3'd4
  } status_t;

  // handle source of an emitted result
  typedef enum logic [1:0] {
    HS_ZERO  = 2'd0,
    HS_FREED = 2'd1,
    HS_MEM   = 2'd2
  } hsel_t;

  typedef struct packed {
    logic    load;
    logic    rf_init;
    logic    rf_rd;
    logic    rf_wr;
    logic    pop_rd;
    logic    sp_init;
    logic    sp_rd;
    logic    sp_wr;
    logic    rel_rd;
    logic    rel_adv;
    logic    sh_rd;
    logic    sh_wr;
    logic    push;
    logic    emit;
    status_t emit_status;
    hsel_t   emit_hsel;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic mode_free;
    logic nomatch;
    logic n_zero;
    logic full;
    logic lm_blocks;
    logic rf_more;
    logic sp_more;
    logic rel_more;
    logic sh_more;
    logic out_free;
  } sts_t;

endpackage

@@ src/sscc_in_if.sv @@
// Request channel: one alloc or free beat.
interface sscc_in_if #(parameter int HANDLE_BITS = 20);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [15:0]            request_length;
  logic [HANDLE_BITS-1:0] freed_handle;
  logic [15:0]            freed_slot_size;

  modport source (output valid, mode, request_length, freed_handle, freed_slot_size,
                  input ready);
  modport sink   (input valid, mode, request_length, freed_handle, freed_slot_size,
                  output ready);
endinterface

@@ src/sscc_out_if.sv @@
// Result channel: one result beat.
interface sscc_out_if #(parameter int HANDLE_BITS = 20);
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [HANDLE_BITS-1:0] handle;
  logic [2:0]             class_id;
  logic                   last;

  modport source (output valid, status, handle, class_id, last, input ready);
  modport sink   (input valid, status, handle, class_id, last, output ready);
endinterface

@@ src/size_class_slot_cache_core.sv @@
// Size class slot cache: per class a local handle stack backed by a global
// FIFO. One request is worked on at a time; the next beat is taken once the
// previous one has written its final result into the output register. A
// refill fetches handles from the global FIFO; a spill moves handles to the
// global FIFO, then releases or shifts the rest down, with up to 16
// releases per beat. The stack and FIFO memories have registered reads.
// Results wait on out_ready.
module size_class_slot_cache_core import sscc_pkg::*; #(
  parameter int CLASS_COUNT  = 6,
  parameter int LOCAL_DEPTH  = 32,
  parameter int GLOBAL_DEPTH = 256,
  parameter int HANDLE_BITS  = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  sscc_in_if.sink                  in_ch,
  sscc_out_if.source               out_ch
);

  cmd_t cmd;
  sts_t sts;

  sscc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sscc_datapath #(
    .CLASS_COUNT  (CLASS_COUNT),
    .LOCAL_DEPTH  (LOCAL_DEPTH),
    .GLOBAL_DEPTH (GLOBAL_DEPTH),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (in_ch.mode),
    .in_request_length  (in_ch.request_length),
    .in_freed_handle    (in_ch.freed_handle),
    .in_freed_slot_size (in_ch.freed_slot_size),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_handle         (out_ch.handle),
    .out_class_id       (out_ch.class_id),
    .out_last           (out_ch.last)
  );

endmodule

@@ src/sscc_datapath.sv @@
// Datapath: config registers, class match, stacks, FIFOs and result register.
module sscc_datapath import sscc_pkg::*; #(
  parameter int CLASS_COUNT  = 6,
  parameter int LOCAL_DEPTH  = 32,
  parameter int GLOBAL_DEPTH = 256,
  parameter int HANDLE_BITS  = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_mode,
  input  logic [LEN_BITS-1:0]      in_request_length,
  input  logic [HANDLE_BITS-1:0]   in_freed_handle,
  input  logic [LEN_BITS-1:0]      in_freed_slot_size,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STATUS_BITS-1:0]   out_status,
  output logic [HANDLE_BITS-1:0]   out_handle,
  output logic [CLASS_FIELD_BITS-1:0] out_class_id,
  output logic                     out_last
);

  localparam int CLW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int LCW = $clog2(LOCAL_DEPTH + 1);
  localparam int GDW = $clog2(GLOBAL_DEPTH);
  localparam int GFW = $clog2(GLOBAL_DEPTH + 1);
  localparam int GSW = GFW + 1;
  localparam int LAW = $clog2(CLASS_COUNT * LOCAL_DEPTH);
  localparam int GAW = $clog2(CLASS_COUNT * GLOBAL_DEPTH);
  localparam int XW0 = (GFW > LCW) ? GFW : LCW;
  localparam int XW  = (XW0 > LOW_MARK_BITS) ? XW0 : LOW_MARK_BITS;

  // configuration
  logic [LEN_BITS-1:0]      class_size_r [CLASS_COUNT];
  logic [LEN_BITS-1:0]      default_len_r;
  logic [LOW_MARK_BITS-1:0] low_mark_r;

  // per-class counters
  logic [LCW-1:0] lcount_r [CLASS_COUNT];
  logic [GDW-1:0] ghead_r  [CLASS_COUNT];
  logic [GFW-1:0] gfill_r  [CLASS_COUNT];

  // item working registers
  logic [CLW-1:0]         cls_r;
  logic                   mode_r;
  logic                   nomatch_r;
  logic [HANDLE_BITS-1:0] h_r;
  logic [LCW-1:0]         n_r;
  logic [LCW-1:0]         src_r;
  logic [LCW-1:0]         dst_r;
  logic [LCW-1:0]         added_r;
  logic [BUDGET_BITS-1:0] k_r;

  // memories with registered read data
  logic [HANDLE_BITS-1:0] lmem [CLASS_COUNT*LOCAL_DEPTH];
  logic [HANDLE_BITS-1:0] gmem [CLASS_COUNT*GLOBAL_DEPTH];
  logic [HANDLE_BITS-1:0] lq_r;
  logic [HANDLE_BITS-1:0] gq_r;

  // result register
  logic                        out_valid_r;
  status_t                     out_status_r;
  logic [HANDLE_BITS-1:0]      out_handle_r;
  logic [CLASS_FIELD_BITS-1:0] out_class_r;
  logic                        out_last_r;

  // class match on the incoming beat
  logic [LEN_BITS-1:0] len_eff;
  logic [CLW-1:0]      m_cls;
  logic                m_found;

  always_comb begin
    len_eff = (in_request_length == '0) ? default_len_r : in_request_length;
    m_cls   = '0;
    m_found = 1'b0;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (in_mode ? (in_freed_slot_size == class_size_r[i])
                  : (len_eff <= class_size_r[i])) begin
        m_cls   = CLW'(i);
        m_found = 1'b1;
      end
    end
  end

  // working values for the current class
  logic [LCW-1:0]  lcount_c;
  logic [GDW-1:0]  ghead_c;
  logic [GFW-1:0]  gfill_c;
  logic [XW-1:0]   lm_x;
  logic [XW-1:0]   want_x;
  logic [XW-1:0]   added_x;
  logic [GSW-1:0]  wsum;
  logic [GDW-1:0]  wpos;
  logic [GDW-1:0]  head_inc;
  logic [LCW-1:0]  lidx_wr;
  logic [LCW-1:0]  lidx_rd;
  logic [LAW-1:0]  laddr_wr;
  logic [LAW-1:0]  laddr_rd;
  logic [GAW-1:0]  gaddr_wr;
  logic [GAW-1:0]  gaddr_rd;
  logic [HANDLE_BITS-1:0] ldata_wr;
  logic            lwe;

  always_comb begin
    lcount_c = lcount_r[cls_r];
    ghead_c  = ghead_r[cls_r];
    gfill_c  = gfill_r[cls_r];
    lm_x     = XW'(low_mark_r);
    want_x   = (lm_x < XW'(LOCAL_DEPTH)) ? lm_x : XW'(LOCAL_DEPTH);
    added_x  = (want_x < XW'(gfill_c)) ? want_x : XW'(gfill_c);
    // tail position of the global ring
    wsum     = GSW'(ghead_c) + GSW'(gfill_c);
    wpos     = GDW'((wsum >= GSW'(GLOBAL_DEPTH)) ? wsum - GSW'(GLOBAL_DEPTH) : wsum);
    head_inc = (GSW'(ghead_c) + GSW'(1) == GSW'(GLOBAL_DEPTH)) ? '0 : ghead_c + GDW'(1);
    // local stack write port
    lwe      = cmd.rf_wr | cmd.sh_wr | cmd.push;
    lidx_wr  = cmd.rf_wr ? n_r : dst_r;
    ldata_wr = cmd.rf_wr ? gq_r : (cmd.sh_wr ? lq_r : h_r);
    lidx_rd  = cmd.pop_rd ? n_r - LCW'(1) : src_r;
    laddr_wr = LAW'(int'(cls_r) * LOCAL_DEPTH + int'(lidx_wr));
    laddr_rd = LAW'(int'(cls_r) * LOCAL_DEPTH + int'(lidx_rd));
    gaddr_wr = GAW'(int'(cls_r) * GLOBAL_DEPTH + int'(wpos));
    gaddr_rd = GAW'(int'(cls_r) * GLOBAL_DEPTH + int'(ghead_c));
  end

  // status towards the controller
  always_comb begin
    sts.mode_free = mode_r;
    sts.nomatch   = nomatch_r;
    sts.n_zero    = (n_r == '0);
    sts.full      = (n_r >= LCW'(LOCAL_DEPTH));
    sts.lm_blocks = (XW'(LOCAL_DEPTH) <= lm_x);
    sts.rf_more   = (n_r < added_r);
    sts.sp_more   = (src_r < n_r) && (gfill_c < GFW'(GLOBAL_DEPTH));
    sts.rel_more  = (src_r < n_r) && (k_r < BUDGET_BITS'(RELEASE_BUDGET));
    sts.sh_more   = (src_r < n_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        class_size_r[i] <= LEN_BITS'(CLASS_SIZE_BASE << i);
        lcount_r[i]     <= '0;
        ghead_r[i]      <= '0;
        gfill_r[i]      <= '0;
      end
      default_len_r <= DEFAULT_LEN_RESET;
      low_mark_r    <= LOW_MARK_RESET;
      cls_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < CLASS_COUNT; i++) begin
          if (i < CFG_CLASS_REGS && cfg_index == CFG_IDX_BITS'(i)) begin
            class_size_r[i] <= cfg_data;
          end
        end
        if (cfg_index == CFG_DEFAULT_LEN) begin
          default_len_r <= cfg_data;
        end
        if (cfg_index == CFG_LOW_MARK) begin
          low_mark_r <= cfg_data[LOW_MARK_BITS-1:0];
        end
      end
      if (cmd.load) begin
        cls_r <= m_cls;
      end
      if (cmd.rf_rd) begin
        ghead_r[cls_r] <= head_inc;
        gfill_r[cls_r] <= gfill_c - GFW'(1);
      end
      if (cmd.sp_wr) begin
        gfill_r[cls_r] <= gfill_c + GFW'(1);
      end
      if (cmd.pop_rd) begin
        lcount_r[cls_r] <= n_r - LCW'(1);
      end
      if (cmd.push) begin
        lcount_r[cls_r] <= dst_r + LCW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      nomatch_r <= !m_found;
      h_r       <= in_freed_handle;
      n_r       <= lcount_r[m_cls];
      dst_r     <= lcount_r[m_cls];
    end
    if (cmd.rf_init) begin
      added_r <= LCW'(added_x);
    end
    if (cmd.rf_wr) begin
      n_r <= n_r + LCW'(1);
    end
    if (cmd.sp_init) begin
      src_r <= LCW'(lm_x);
      dst_r <= LCW'(lm_x);
      k_r   <= '0;
    end
    if (cmd.sp_wr) begin
      src_r <= src_r + LCW'(1);
    end
    if (cmd.rel_adv) begin
      src_r <= src_r + LCW'(1);
      k_r   <= k_r + BUDGET_BITS'(1);
    end
    if (cmd.sh_wr) begin
      src_r <= src_r + LCW'(1);
      dst_r <= dst_r + LCW'(1);
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_class_r  <= CLASS_FIELD_BITS'(cls_r);
      out_last_r   <= cmd.emit_last;
      unique case (cmd.emit_hsel)
        HS_FREED: out_handle_r <= h_r;
        HS_MEM:   out_handle_r <= lq_r;
        default:  out_handle_r <= '0;
      endcase
    end
  end

  // local stacks: one write, one read a cycle
  always_ff @(posedge clk) begin
    if (lwe) begin
      lmem[laddr_wr] <= ldata_wr;
    end
    if (cmd.pop_rd || cmd.sp_rd || cmd.rel_rd || cmd.sh_rd) begin
      lq_r <= lmem[laddr_rd];
    end
  end

  // global FIFOs: one write, one read a cycle
  always_ff @(posedge clk) begin
    if (cmd.sp_wr) begin
      gmem[gaddr_wr] <= lq_r;
    end
    if (cmd.rf_rd) begin
      gq_r <= gmem[gaddr_rd];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_handle   = out_handle_r;
  assign out_class_id = out_class_r;
  assign out_last     = out_last_r;

  a_lcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    lcount_r[cls_r] <= LCW'(LOCAL_DEPTH))
    else $error("local count beyond stack depth");

  a_gfill_range: assert property (@(posedge clk) disable iff (!rst_n)
    gfill_r[cls_r] <= GFW'(GLOBAL_DEPTH))
    else $error("global fill beyond FIFO depth");

  a_spill_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sp_wr |-> gfill_c < GFW'(GLOBAL_DEPTH))
    else $error("spill into a full global FIFO");

endmodule

@@ src/sscc_ctrl.sv @@
// Controller: sequences refill, pop, spill, release, shift and push.
module sscc_ctrl import sscc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DECIDE  = 14'b00000000000010,
    S_RF_RD   = 14'b00000000000100,
    S_RF_WR   = 14'b00000000001000,
    S_ACHK    = 14'b00000000010000,
    S_POP_RD  = 14'b00000000100000,
    S_POP_OUT = 14'b00000001000000,
    S_SP_RD   = 14'b00000010000000,
    S_SP_WR   = 14'b00000100000000,
    S_REL_RD  = 14'b00001000000000,
    S_REL_OUT = 14'b00010000000000,
    S_SH_RD   = 14'b00100000000000,
    S_SH_WR   = 14'b01000000000000,
    S_PUSH    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.mode_free) begin
          if (sts.nomatch) begin
            if (sts.out_free) begin
              cmd.emit = 1'b1; cmd.emit_status = ST_NO_FIT;
              cmd.emit_hsel = HS_ZERO; cmd.emit_last = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (sts.n_zero) begin
            cmd.rf_init = 1'b1;
            state_nxt   = S_RF_RD;
          end else begin
            state_nxt = S_POP_RD;
          end
        end else begin
          if (sts.nomatch || (sts.full && sts.lm_blocks)) begin
            if (sts.out_free) begin
              cmd.emit = 1'b1; cmd.emit_status = ST_RELEASE;
              cmd.emit_hsel = HS_FREED; cmd.emit_last = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (sts.full) begin
            cmd.sp_init = 1'b1;
            state_nxt   = S_SP_RD;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      // refill from the global FIFO
      S_RF_RD: begin
        if (sts.rf_more) begin
          cmd.rf_rd = 1'b1;
          state_nxt = S_RF_WR;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_RF_WR: begin
        cmd.rf_wr = 1'b1;
        state_nxt = S_RF_RD;
      end
      S_ACHK: begin
        if (sts.n_zero) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1; cmd.emit_status = ST_NEW_PAGE;
            cmd.emit_hsel = HS_ZERO; cmd.emit_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1; cmd.emit_status = ST_GRANTED;
          cmd.emit_hsel = HS_MEM; cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // spill above the low mark into the global FIFO
      S_SP_RD: begin
        if (sts.sp_more) begin
          cmd.sp_rd = 1'b1;
          state_nxt = S_SP_WR;
        end else begin
          state_nxt = S_REL_RD;
        end
      end
      S_SP_WR: begin
        cmd.sp_wr = 1'b1;
        state_nxt = S_SP_RD;
      end
      // release what did not fit
      S_REL_RD: begin
        if (sts.rel_more) begin
          cmd.rel_rd = 1'b1;
          state_nxt  = S_REL_OUT;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_REL_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1; cmd.emit_status = ST_RELEASE;
          cmd.emit_hsel = HS_MEM; cmd.emit_last = 1'b0;
          cmd.rel_adv = 1'b1;
          state_nxt = S_REL_RD;
        end
      end
      // move the leftovers down onto the low mark
      S_SH_RD: begin
        if (sts.sh_more) begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SH_RD;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          cmd.emit = 1'b1; cmd.emit_status = ST_CACHED;
          cmd.emit_hsel = HS_FREED; cmd.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result beat written over a pending one");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DECIDE)
    else $error("accepted beat not decided next");

endmodule

@@ verif/tb_size_class_slot_cache_core.sv @@
// Testbench for the size class slot cache core: self-checking, with its own predictor.
module tb_size_class_slot_cache_core;
  import sscc_pkg::*;

  localparam int NCLS       = 6;
  localparam int LDEPTH     = 32;
  localparam int GDEPTH     = 256;
  localparam int HBITS      = 20;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic             mode;
    logic [15:0]      len;
    logic [HBITS-1:0] hdl;
    logic [15:0]      sz;
  } request_t;

  typedef struct {
    status_t          status;
    logic [HBITS-1:0] hdl;
    logic [2:0]       cls;
    logic             last;
  } slot_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  sscc_in_if  #(.HANDLE_BITS(HBITS)) in_ch ();
  sscc_out_if #(.HANDLE_BITS(HBITS)) out_ch ();

  size_class_slot_cache_core #(
    .CLASS_COUNT(NCLS), .LOCAL_DEPTH(LDEPTH), .GLOBAL_DEPTH(GDEPTH), .HANDLE_BITS(HBITS)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor copy of the cache contents and registers
  logic [HBITS-1:0] stack_mem [NCLS][LDEPTH];
  int               stack_cnt [NCLS];
  logic [HBITS-1:0] fifo_mem  [NCLS][GDEPTH];
  int               fifo_head [NCLS];
  int               fifo_fill [NCLS];
  int               class_bytes [NCLS];
  int               dflt_len;
  int               low_mark;

  request_t     pending_reqs[$];
  slot_result_t expected_results[$];
  int           errors;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           recv_hold;
  logic         in_taken;

  // clock
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // work out the results of one accepted request
  function automatic void predict_request(request_t r);
    slot_result_t outs[$];
    int len, c, n, want, added, src, room, pos, kept, rel;
    if (r.mode == 1'b0) begin
      len = (r.len == 0) ? dflt_len : int'(r.len);
      for (c = 0; c < NCLS; c++) if (len <= class_bytes[c]) break;
      if (c >= NCLS) begin
        outs.push_back('{ST_NO_FIT, '0, 3'd0, 1'b0});
      end else begin
        n = stack_cnt[c];
        if (n == 0) begin
          want  = (low_mark < LDEPTH) ? low_mark : LDEPTH;
          added = (want < fifo_fill[c]) ? want : fifo_fill[c];
          for (int i = 0; i < added; i++) begin
            stack_mem[c][i] = fifo_mem[c][fifo_head[c]];
            fifo_head[c] = (fifo_head[c] + 1) % GDEPTH;
          end
          fifo_fill[c] -= added;
          n = added;
        end
        if (n == 0) begin
          stack_cnt[c] = 0;
          outs.push_back('{ST_NEW_PAGE, '0, 3'(c), 1'b0});
        end else begin
          n--;
          stack_cnt[c] = n;
          outs.push_back('{ST_GRANTED, stack_mem[c][n], 3'(c), 1'b0});
        end
      end
    end else begin
      for (c = 0; c < NCLS; c++) if (int'(r.sz) == class_bytes[c]) break;
      if (c >= NCLS) begin
        outs.push_back('{ST_RELEASE, r.hdl, 3'd0, 1'b0});
      end else begin
        n = stack_cnt[c];
        if (n >= LDEPTH && n <= low_mark) begin
          outs.push_back('{ST_RELEASE, r.hdl, 3'(c), 1'b0});
        end else begin
          if (n >= LDEPTH) begin
            // spill: to the global FIFO first, then release, the rest shifts down
            src  = low_mark;
            room = GDEPTH - fifo_fill[c];
            while (src < n && room > 0) begin
              pos = (fifo_head[c] + fifo_fill[c]) % GDEPTH;
              fifo_mem[c][pos] = stack_mem[c][src];
              fifo_fill[c]++;
              room--;
              src++;
            end
            rel = 0;
            while (src < n && rel < RELEASE_BUDGET) begin
              outs.push_back('{ST_RELEASE, stack_mem[c][src], 3'(c), 1'b0});
              rel++;
              src++;
            end
            kept = n - src;
            for (int i = 0; i < kept; i++) stack_mem[c][low_mark + i] = stack_mem[c][src + i];
            n = low_mark + kept;
          end
          stack_mem[c][n] = r.hdl;
          stack_cnt[c] = n + 1;
          outs.push_back('{ST_CACHED, r.hdl, 3'(c), 1'b0});
        end
      end
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endfunction

  // sender and receiver, driven on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  = 1'b0;
      out_ch.ready = 1'b0;
    end else begin
      if (!(in_ch.valid && !in_taken)) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.mode            = pending_reqs[0].mode;
          in_ch.request_length  = pending_reqs[0].len;
          in_ch.freed_handle    = pending_reqs[0].hdl;
          in_ch.freed_slot_size = pending_reqs[0].sz;
          in_ch.valid           = 1'b1;
        end else begin
          in_ch.valid = 1'b0;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // accepted beats, result checking and the watchdog
  always @(posedge clk) begin
    slot_result_t exp_r;
    request_t     req;
    if (!rst_n) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        req = '{in_ch.mode, in_ch.request_length, in_ch.freed_handle, in_ch.freed_slot_size};
        predict_request(req);
        void'(pending_reqs.pop_front());
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d handle %h class %0d last %b",
                     out_ch.status, out_ch.handle, out_ch.class_id, out_ch.last);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.status !== exp_r.status || out_ch.handle !== exp_r.hdl ||
              out_ch.class_id !== exp_r.cls || out_ch.last !== exp_r.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d h %h c %0d l %b, got st %0d h %h c %0d l %b",
                       exp_r.status, exp_r.hdl, exp_r.cls, exp_r.last, out_ch.status,
                       out_ch.handle, out_ch.class_id, out_ch.last);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_alloc(int len);
    pending_reqs.push_back('{1'b0, 16'(len), 20'($urandom), 16'($urandom)});
  endtask

  task automatic add_free(int hdl, int sz);
    pending_reqs.push_back('{1'b1, 16'($urandom), 20'(hdl), 16'(sz)});
  endtask

  // wait until every beat is out, then let the block settle
  task automatic drain;
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = 16'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < CFG_CLASS_REGS) class_bytes[idx] = val & 16'hFFFF;
    else if (idx == CFG_DEFAULT_LEN) dflt_len = val & 16'hFFFF;
    else if (idx == CFG_LOW_MARK) low_mark = val & 5'h1F;
  endtask

  // random mix aimed at a few classes so stacks fill and spill
  task automatic add_random(int count);
    int c, pick;
    for (int i = 0; i < count; i++) begin
      c    = $urandom_range(0, 99) < 60 ? $urandom_range(0, 1) : $urandom_range(0, NCLS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 45)      add_free($urandom, class_bytes[c]);
      else if (pick < 50) add_free($urandom, $urandom_range(0, 65535));
      else if (pick < 80) add_alloc(class_bytes[c]);
      else if (pick < 90) add_alloc($urandom_range(0, 65535));
      else if (pick < 95) add_alloc(0);
      else                add_alloc(class_bytes[c] + 1);
    end
  endtask

  initial begin
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = 1'b0;
    in_ch.request_length  = '0;
    in_ch.freed_handle    = '0;
    in_ch.freed_slot_size = '0;
    out_ch.ready   = 1'b0;
    for (int c = 0; c < NCLS; c++) begin
      class_bytes[c] = 64 << c;
      stack_cnt[c] = 0;
      fifo_head[c] = 0;
      fifo_fill[c] = 0;
    end
    dflt_len = 2048;
    low_mark = 16;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty stores, no fit, unmatched frees, extreme handles
    add_alloc(0);
    add_alloc(65535);
    add_alloc(1);
    add_alloc(2049);
    add_free(20'hFFFFF, 64);
    add_free(0, 2048);
    add_free(20'h5A5A5, 0);
    add_free(20'hA5A5A, 65535);
    add_alloc(64);
    add_alloc(0);
    add_alloc(0);
    add_free(20'h12345, 1024);
    add_free(20'hEDCBA, 1024);
    add_alloc(513);
    add_alloc(1024);
    add_alloc(1000);
    drain();

    // odd sizes and extreme registers
    write_reg(3'd0, 1);
    write_reg(3'd1, 2);
    write_reg(3'd2, 100);
    write_reg(3'd3, 1000);
    write_reg(3'd4, 40000);
    write_reg(3'd5, 65535);
    write_reg(CFG_DEFAULT_LEN, 1);
    write_reg(CFG_LOW_MARK, 31);
    add_random(25);
    drain();

    // fill one class past a spill with low mark 1; the receiver holds off
    // first so the input backs up
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    write_reg(CFG_LOW_MARK, 1);
    recv_hold = 400;
    for (int i = 0; i < 40; i++) add_free($urandom, 1);
    drain();
    // low mark zero: full spill, then allocs that refill nothing
    write_reg(CFG_LOW_MARK, 0);
    for (int i = 0; i < 35; i++) add_free($urandom, 1);
    for (int i = 0; i < 15; i++) add_alloc($urandom_range(0, 1));
    drain();

    // low mark 3 refill path with a slow sender
    send_idle_pct  = 67;
    recv_stall_pct = 0;
    write_reg(CFG_LOW_MARK, 3);
    write_reg(CFG_DEFAULT_LEN, 65535);
    for (int i = 0; i < 15; i++) add_alloc(1);
    add_random(15);
    drain();

    // reset-like sizes, slow receiver
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    for (int c = 0; c < NCLS; c++) write_reg(3'(c), 64 << c);
    write_reg(CFG_DEFAULT_LEN, 300);
    write_reg(CFG_LOW_MARK, 16);
    add_random(25);
    drain();

    // both sides idle
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    add_random(25);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sscc_pkg.sv
src/sscc_in_if.sv
src/sscc_out_if.sv
src/sscc_datapath.sv
src/sscc_ctrl.sv
src/size_class_slot_cache_core.sv
verif/tb_size_class_slot_cache_core.sv
